### hdl/mrhpf_pkg.sv
`timescale 1ns / 1ps

package mrhpf_pkg;

    // frame field widths
    localparam int ByteW  = 8;
    localparam int PanW   = 16;
    localparam int AddrW  = 64;
    localparam int PosW   = 5;

    // header layout
    localparam int MinHeader = 3;
    localparam int PanLen    = 2;
    localparam int ExtLen    = 8;
    localparam int ShortLen  = 2;
    localparam int MaxHeader = MinHeader + 2 * (PanLen + ExtLen);

    // result status codes
    localparam logic [2:0] StOk        = 3'd0;
    localparam logic [2:0] StTruncated = 3'd1;
    localparam logic [2:0] StSecurity  = 3'd2;
    localparam logic [2:0] StAckAddr   = 3'd3;
    localparam logic [2:0] StReserved  = 3'd4;
    localparam logic [2:0] StUnknown   = 3'd5;

    // address filter verdicts
    localparam logic [1:0] ClassHost      = 2'd0;
    localparam logic [1:0] ClassBroadcast = 2'd1;
    localparam logic [1:0] ClassOther     = 2'd2;

    // addressing modes
    localparam logic [1:0] ModeNone     = 2'd0;
    localparam logic [1:0] ModeReserved = 2'd1;
    localparam logic [1:0] ModeShort    = 2'd2;
    localparam logic [1:0] ModeLong     = 2'd3;

    // frame types
    localparam logic [2:0] TypeAck     = 3'd2;
    localparam logic [2:0] TypeLastStd = 3'd3;

    // configuration register indexes
    localparam logic [1:0] CfgOwnPan   = 2'd0;
    localparam logic [1:0] CfgOwnShort = 2'd1;
    localparam logic [1:0] CfgOwnExt   = 2'd2;

    localparam logic [PanW-1:0] PanBroadcast = 16'hffff;

    // parsed header handed from the parser to the filter and output stage
    typedef struct packed {
        logic [2:0]       status;
        logic [2:0]       frame_type;
        logic             ack_request;
        logic [ByteW-1:0] sequence_number;
        logic [1:0]       dst_mode;
        logic [PanW-1:0]  dst_pan;
        logic [AddrW-1:0] dst_addr;
        logic [1:0]       src_mode;
        logic [PanW-1:0]  src_pan;
        logic [AddrW-1:0] src_addr;
    } t_hdr;

    // address field length in bytes for a mode
    function automatic logic [PosW-1:0] field_bytes(input logic [1:0] mode);
        logic [PosW-1:0] len;
        len = '0;
        if (mode == ModeLong) begin
            len = PosW'(ExtLen);
        end else if (mode == ModeShort) begin
            len = PosW'(ShortLen);
        end
        return len;
    endfunction

endpackage

### hdl/mac_rx_header_parse_filter_unit.sv
`timescale 1ns / 1ps

// 802.15.4 receive header parser and address filter
//
// input channel: one received byte per transfer on i_frame_byte, with
// i_frame_start on the first byte of a frame and i_frame_end on the last.
// output channel: one result per frame, when the header is complete or an
// error is known: status, frame control fields, sequence number, both
// address fields and the filter verdict against the own pan and addresses.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 own pan id, 1 own short address, 2 own extended address); write only
// while no frame is in flight.
//
// throughput is one byte per cycle while the receiver takes results. a byte is
// held in the input register, the parser and filter logic then load the result
// register, so o_out_valid rises once the byte that completes the header has
// passed through the input register and the result register.
// when the receiver stalls, the result register holds and the input
// register fills; o_in_ready drops only while both are full.
// reset empties both registers and leaves the parser waiting for a frame
// start; bytes before a start or after a frame's result are dropped.
module mac_rx_header_parse_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_frame_type,
    output logic        o_ack_request,
    output logic [7:0]  o_sequence_number,
    output logic [1:0]  o_dst_mode,
    output logic [15:0] o_dst_pan,
    output logic [63:0] o_dst_addr,
    output logic [1:0]  o_src_mode,
    output logic [15:0] o_src_pan,
    output logic [63:0] o_src_addr,
    output logic [1:0]  o_packet_class,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import mrhpf_pkg::*;

    logic [15:0] r_own_pan;
    logic [15:0] r_own_short;
    logic [63:0] r_own_ext;

    logic        r_iv;
    logic [7:0]  r_byte;
    logic        r_start;
    logic        r_end;
    logic        r_ov;
    t_hdr        r_hdr;
    logic [1:0]  r_class;

    logic        adv;
    logic        step;
    logic        emit;
    t_hdr        hdr;
    logic [1:0]  pkt_class;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_pan   <= PanBroadcast;
            r_own_short <= 16'hffff;
            r_own_ext   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgOwnPan:   r_own_pan   <= i_cfg_data[15:0];
                CfgOwnShort: r_own_short <= i_cfg_data[15:0];
                CfgOwnExt:   r_own_ext   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // stage advance when the result slot is free or being drained
    assign adv        = !r_ov || i_out_ready;
    assign step       = r_iv && adv;
    assign o_in_ready = !r_iv || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_iv <= 1'b1;
        end else if (step) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte  <= i_frame_byte;
            r_start <= i_frame_start;
            r_end   <= i_frame_end;
        end
    end

    mrhpf_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_byte),
        .i_start (r_start),
        .i_end   (r_end),
        .o_emit  (emit),
        .o_hdr   (hdr)
    );

    mrhpf_filter u_filter (
        .i_hdr       (hdr),
        .i_own_pan   (r_own_pan),
        .i_own_short (r_own_short),
        .i_own_ext   (r_own_ext),
        .o_class     (pkt_class)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_hdr   <= hdr;
            r_class <= pkt_class;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_status          = r_hdr.status;
    assign o_frame_type      = r_hdr.frame_type;
    assign o_ack_request     = r_hdr.ack_request;
    assign o_sequence_number = r_hdr.sequence_number;
    assign o_dst_mode        = r_hdr.dst_mode;
    assign o_dst_pan         = r_hdr.dst_pan;
    assign o_dst_addr        = r_hdr.dst_addr;
    assign o_src_mode        = r_hdr.src_mode;
    assign o_src_pan         = r_hdr.src_pan;
    assign o_src_addr        = r_hdr.src_addr;
    assign o_packet_class    = r_class;

    // error results carry no filter verdict
    a_err_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != StOk) |-> (o_packet_class == ClassHost))
        else $error("filter verdict on an error result");

    // input backpressure only when both registers are full and stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_iv && r_ov && !i_out_ready))
        else $error("input stalled without a full pipeline");

endmodule

### hdl/mrhpf_parse.sv
`timescale 1ns / 1ps

module mrhpf_parse (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    input  logic                    i_start,
    input  logic                    i_end,
    output logic                    o_emit,
    output mrhpf_pkg::t_hdr         o_hdr
);
    import mrhpf_pkg::*;

    logic [PosW-1:0]  r_pos, n_pos;
    logic             r_done, n_done;
    logic [15:0]      r_ctrl, n_ctrl;
    logic [ByteW-1:0] r_seq, n_seq;
    logic [PanW-1:0]  r_dpan, n_dpan;
    logic [AddrW-1:0] r_daddr, n_daddr;
    logic [PanW-1:0]  r_span, n_span;
    logic [AddrW-1:0] r_saddr, n_saddr;

    logic [PosW-1:0]  base_pos;
    logic             base_done;
    logic [PanW-1:0]  clr_dpan, clr_span;
    logic [AddrW-1:0] clr_daddr, clr_saddr;
    logic [1:0]       dm, sm;
    logic             comp;
    logic [PosW-1:0]  dlen, slen, so, sa, hdr;
    logic             emit;
    logic [2:0]       status;

    // frame start clears the capture state
    always_comb begin
        base_pos  = i_start ? '0 : r_pos;
        base_done = i_start ? 1'b0 : r_done;
        n_ctrl    = i_start ? '0 : r_ctrl;
        n_seq     = i_start ? '0 : r_seq;
        clr_dpan  = i_start ? '0 : r_dpan;
        clr_daddr = i_start ? '0 : r_daddr;
        clr_span  = i_start ? '0 : r_span;
        clr_saddr = i_start ? '0 : r_saddr;

        // fixed header bytes
        if (base_pos == PosW'(0)) begin
            n_ctrl = {8'h00, i_byte};
        end else if (base_pos == PosW'(1)) begin
            n_ctrl = {i_byte, n_ctrl[7:0]};
        end else if (base_pos == PosW'(2)) begin
            n_seq = i_byte;
        end
    end

    // address field layout from the frame control word
    always_comb begin
        dm   = n_ctrl[11:10];
        sm   = n_ctrl[15:14];
        comp = n_ctrl[6];
        dlen = field_bytes(dm);
        slen = field_bytes(sm);
        so   = (dm != ModeNone) ? PosW'(MinHeader + PanLen) + dlen : PosW'(MinHeader);
        sa   = comp ? so : so + PosW'(PanLen);
        hdr  = (sm != ModeNone) ? sa + slen : so;
    end

    // byte lane capture for the address fields
    always_comb begin
        n_dpan  = clr_dpan;
        n_daddr = clr_daddr;
        n_span  = clr_span;
        n_saddr = clr_saddr;
        for (int k = 0; k < PanLen; k++) begin
            if (dm != ModeNone && base_pos == PosW'(MinHeader + k)) begin
                n_dpan[8*k +: 8] = i_byte;
            end
            if (sm != ModeNone && !comp && base_pos == so + PosW'(k)) begin
                n_span[8*k +: 8] = i_byte;
            end
        end
        for (int k = 0; k < ExtLen; k++) begin
            if (dm != ModeNone && PosW'(k) < dlen
                && base_pos == PosW'(MinHeader + PanLen + k)) begin
                n_daddr[8*k +: 8] = i_byte;
            end
            if (sm != ModeNone && PosW'(k) < slen && base_pos == sa + PosW'(k)) begin
                n_saddr[8*k +: 8] = i_byte;
            end
        end
    end

    // result decision, errors on the third byte take priority
    always_comb begin
        emit   = 1'b0;
        status = StOk;
        if (base_pos == PosW'(2) && n_ctrl[3]) begin
            emit   = 1'b1;
            status = StSecurity;
        end else if (base_pos == PosW'(2) && n_ctrl[2:0] == TypeAck
                     && (dm != ModeNone || sm != ModeNone)) begin
            emit   = 1'b1;
            status = StAckAddr;
        end else if (base_pos == PosW'(2) && (dm == ModeReserved || sm == ModeReserved)) begin
            emit   = 1'b1;
            status = StReserved;
        end else if (base_pos >= PosW'(2) && base_pos + PosW'(1) == hdr) begin
            emit   = 1'b1;
            status = (n_ctrl[2:0] > TypeLastStd) ? StUnknown : StOk;
        end else if (i_end) begin
            emit   = 1'b1;
            status = StTruncated;
        end
        if (base_done) begin
            emit = 1'b0;
        end
        n_done = base_done || emit;
        n_pos  = (base_done || emit) ? base_pos : base_pos + PosW'(1);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_done <= 1'b1;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_done <= n_done;
        end
    end

    // captured header fields, only touched while a frame is open
    always_ff @(posedge i_clk) begin
        if (i_step && !base_done) begin
            r_ctrl  <= n_ctrl;
            r_seq   <= n_seq;
            r_dpan  <= n_dpan;
            r_daddr <= n_daddr;
            r_span  <= n_span;
            r_saddr <= n_saddr;
        end
    end

    assign o_emit = i_step && emit;

    always_comb begin
        o_hdr.status          = status;
        o_hdr.frame_type      = n_ctrl[2:0];
        o_hdr.ack_request     = n_ctrl[5];
        o_hdr.sequence_number = n_seq;
        o_hdr.dst_mode        = dm;
        o_hdr.dst_pan         = n_dpan;
        o_hdr.dst_addr        = n_daddr;
        o_hdr.src_mode        = sm;
        o_hdr.src_pan         = comp ? n_dpan : n_span;
        o_hdr.src_addr        = n_saddr;
    end

    // open frame never runs past the longest header
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> (r_pos < PosW'(MaxHeader)))
        else $error("parser position beyond longest header");

    // a result closes the frame
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_done)
        else $error("frame still open after result");

    // reserved modes never pass as a good header
    a_no_reserved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && (o_hdr.status == StOk)
            |-> (o_hdr.dst_mode != ModeReserved && o_hdr.src_mode != ModeReserved))
        else $error("reserved address mode reported as ok");

endmodule

### hdl/mrhpf_filter.sv
`timescale 1ns / 1ps

module mrhpf_filter (
    input  mrhpf_pkg::t_hdr  i_hdr,
    input  logic [15:0]      i_own_pan,
    input  logic [15:0]      i_own_short,
    input  logic [63:0]      i_own_ext,
    output logic [1:0]       o_class
);
    import mrhpf_pkg::*;

    logic pan_ok;

    assign pan_ok = (i_hdr.dst_pan == i_own_pan) || (i_hdr.dst_pan == PanBroadcast);

    // destination address against own pan and addresses; error results and frames without any address go to the host
    always_comb begin
        o_class = ClassOther;
        if (i_hdr.status != StOk) begin
            o_class = ClassHost;
        end else if (i_hdr.dst_mode == ModeNone) begin
            o_class = (i_hdr.src_mode != ModeNone) ? ClassOther : ClassHost;
        end else if (!pan_ok) begin
            o_class = ClassOther;
        end else if (i_hdr.dst_mode == ModeLong) begin
            o_class = (i_hdr.dst_addr == i_own_ext) ? ClassHost : ClassOther;
        end else if (i_hdr.dst_addr[15:0] == i_own_short) begin
            o_class = ClassHost;
        end else if (i_hdr.dst_addr[15:0] == PanBroadcast) begin
            o_class = ClassBroadcast;
        end
    end

endmodule
